// ===== hw/rtl/vrh_pkg.sv =====
// Shared types and constants for the value range histogram.
package vrh_pkg;

    localparam int BINS           = 256;
    localparam int BIN_BITS       = 8;
    localparam int COUNT_BITS     = 32;
    localparam int DATA_BITS      = 32;
    localparam int NBINS_BITS     = 9;
    localparam int CFG_INDEX_BITS = 2;
    localparam int OP_BITS        = 2;
    // sample - lower_bound and upper_bound - lower_bound
    localparam int DIFF_BITS      = DATA_BITS + 1;
    // (bins - 1) * difference, signed, and its magnitude
    localparam int NUM_BITS       = DIFF_BITS + NBINS_BITS;
    localparam int MAG_BITS       = NUM_BITS - 1;
    localparam int STEP_BITS      = $clog2(BIN_BITS);
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOWER_BOUND = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UPPER_BOUND = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_BINS_IN_USE = 2'd2;

    localparam logic signed [DATA_BITS-1:0] LOWER_RESET = 32'sd0;
    localparam logic signed [DATA_BITS-1:0] UPPER_RESET = 32'sd65536;
    localparam logic [NBINS_BITS-1:0]       BINS_RESET  = 9'd256;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD        = 2'd0,
        OP_READ       = 2'd1,
        OP_READ_CLEAR = 2'd2,
        OP_NONE       = 2'd3
    } op_t;

    // Command handed from the classifier to the counter stage
    typedef struct packed {
        op_t                 kind;
        logic [BIN_BITS-1:0] slot;
    } cmd_t;

    typedef enum logic [2:0] {
        FE_IDLE,
        FE_MUL,
        FE_ABS,
        FE_CHK,
        FE_DIV,
        FE_PUSH
    } fe_state_t;

    typedef enum logic {
        BE_IDLE,
        BE_READ
    } be_state_t;

endpackage

// ===== hw/rtl/value_range_histogram.sv =====
// Top level of the value range histogram: classifier, command queue, counter stage.
// An add item that reaches the divider passes through these classifier steps, and the
// classifier takes no next item until they are done: accept, multiply (bins-1)*(sample-
// lower_bound), take magnitudes, range check, eight restoring-division steps (one
// quotient bit each) and hand the bin to the queue. An add whose quotient is 256 or more
// leaves after the range check; reads, no-ops and adds dropped for a zero range or zero
// bins go straight from accept to the hand-over, which stalls while the queue is full. The
// counter stage handles each command with a registered read of the counter memory, then
// a write, and takes no new command until the write is done. A four-entry queue lets the
// classifier keep going while results wait. Counters start at zero after reset through
// a per-bin written flag, with no clearing pass. Configuration may be written only
// while no item is in flight.
module value_range_histogram (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [vrh_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [vrh_pkg::DATA_BITS-1:0]         cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [vrh_pkg::OP_BITS-1:0]           s_operation,
    input  logic signed [vrh_pkg::DATA_BITS-1:0]  s_sample,
    input  logic [vrh_pkg::BIN_BITS-1:0]          s_bin_index,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [vrh_pkg::BIN_BITS-1:0]          m_bin_slot,
    output logic                                  m_counted,
    output logic [vrh_pkg::COUNT_BITS-1:0]        m_bin_count
);
    import vrh_pkg::*;

    cmd_t push_cmd;
    cmd_t pop_cmd;
    logic push_valid;
    logic push_ready;
    logic pop_valid;
    logic pop_ready;

    vrh_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_sample    (s_sample),
        .s_bin_index (s_bin_index),
        .push_valid  (push_valid),
        .push_ready  (push_ready),
        .push_cmd    (push_cmd)
    );

    vrh_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    vrh_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_cmd     (pop_cmd),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_bin_slot  (m_bin_slot),
        .m_counted   (m_counted),
        .m_bin_count (m_bin_count)
    );

endmodule

// ===== hw/rtl/vrh_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module vrh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int ADDR_BITS = $clog2(DEPTH)
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/vrh_front.sv =====
// Front part: configuration registers, item intake and bin classification.
module vrh_front (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [vrh_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [vrh_pkg::DATA_BITS-1:0]         cfg_wdata,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [vrh_pkg::OP_BITS-1:0]           s_operation,
    input  logic signed [vrh_pkg::DATA_BITS-1:0]  s_sample,
    input  logic [vrh_pkg::BIN_BITS-1:0]          s_bin_index,
    output logic                                  push_valid,
    input  logic                                  push_ready,
    output vrh_pkg::cmd_t                         push_cmd
);
    import vrh_pkg::*;

    logic signed [DATA_BITS-1:0] lower_reg;
    logic signed [DATA_BITS-1:0] upper_reg;
    logic [NBINS_BITS-1:0]       bins_reg;

    fe_state_t state_reg, state_next;

    op_t                         op_reg;
    logic [BIN_BITS-1:0]         idx_reg;
    logic signed [DIFF_BITS-1:0] diff_reg;
    logic signed [DIFF_BITS-1:0] den_reg;
    logic [BIN_BITS-1:0]         nm1_reg;
    logic                        drop_reg;
    logic signed [NUM_BITS-1:0]  prod_reg;
    logic [MAG_BITS-1:0]         num_mag_reg;
    logic [DIFF_BITS-1:0]        den_mag_reg;
    logic                        neg_reg;
    logic [MAG_BITS-1:0]         rem_reg;
    logic [MAG_BITS-1:0]         dsh_reg;
    logic [BIN_BITS-1:0]         quo_reg;
    logic [STEP_BITS-1:0]        step_reg;

    logic                        accept;
    logic signed [DIFF_BITS-1:0] diff_in;
    logic signed [DIFF_BITS-1:0] den_in;
    logic [NBINS_BITS-1:0]       n_clip;
    logic [NBINS_BITS-1:0]       nm1_wide;
    logic                        drop_in;
    logic signed [NBINS_BITS-1:0] nm1_s;
    logic signed [NUM_BITS-1:0]  prod_in;
    logic signed [NUM_BITS-1:0]  prod_neg;
    logic signed [DIFF_BITS-1:0] den_neg;
    logic                        over;
    logic                        rem_ge;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_reg <= LOWER_RESET;
            upper_reg <= UPPER_RESET;
            bins_reg  <= BINS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_LOWER_BOUND: lower_reg <= signed'(cfg_wdata);
                CFG_UPPER_BOUND: upper_reg <= signed'(cfg_wdata);
                CFG_BINS_IN_USE: bins_reg  <= cfg_wdata[NBINS_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign accept   = s_valid && s_ready;
    assign diff_in  = DIFF_BITS'(s_sample) - DIFF_BITS'(lower_reg);
    assign den_in   = DIFF_BITS'(upper_reg) - DIFF_BITS'(lower_reg);
    assign n_clip   = (bins_reg > NBINS_BITS'(BINS)) ? NBINS_BITS'(BINS) : bins_reg;
    assign nm1_wide = n_clip - NBINS_BITS'(1);
    assign drop_in  = (bins_reg == '0) || (den_in == '0);
    assign nm1_s    = signed'({1'b0, nm1_reg});
    assign prod_in  = nm1_s * diff_reg;
    assign prod_neg = -prod_reg;
    assign den_neg  = -den_reg;
    // Quotient of 256 or more can never land in a bin in use
    assign over     = num_mag_reg >= MAG_BITS'({den_mag_reg, {BIN_BITS{1'b0}}});
    assign rem_ge   = rem_reg >= dsh_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            FE_IDLE: begin
                if (s_valid) begin
                    if (op_t'(s_operation) == OP_ADD && !drop_in) begin
                        state_next = FE_MUL;
                    end else begin
                        state_next = FE_PUSH;
                    end
                end
            end
            FE_MUL: state_next = FE_ABS;
            FE_ABS: state_next = FE_CHK;
            FE_CHK: state_next = over ? FE_PUSH : FE_DIV;
            FE_DIV: begin
                if (step_reg == '0) begin
                    state_next = FE_PUSH;
                end
            end
            FE_PUSH: begin
                if (push_ready) begin
                    state_next = FE_IDLE;
                end
            end
            default: state_next = FE_IDLE;
        endcase
    end

    always_comb begin
        s_ready       = (state_reg == FE_IDLE);
        push_valid    = (state_reg == FE_PUSH);
        push_cmd.kind = OP_NONE;
        push_cmd.slot = '0;
        case (op_reg)
            OP_ADD: begin
                // Truncation toward zero keeps small negative quotients in bin 0
                if (!drop_reg && !(neg_reg && quo_reg != '0) && quo_reg <= nm1_reg) begin
                    push_cmd.kind = OP_ADD;
                    push_cmd.slot = quo_reg;
                end
            end
            OP_READ, OP_READ_CLEAR: begin
                push_cmd.kind = op_reg;
                push_cmd.slot = idx_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= FE_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Datapath: capture the item, multiply, take magnitudes, check the range, then one quotient bit per cycle
    always_ff @(posedge aclk) begin
        case (state_reg)
            FE_IDLE: begin
                if (accept) begin
                    op_reg   <= op_t'(s_operation);
                    idx_reg  <= s_bin_index;
                    diff_reg <= diff_in;
                    den_reg  <= den_in;
                    nm1_reg  <= nm1_wide[BIN_BITS-1:0];
                    drop_reg <= drop_in;
                end
            end
            FE_MUL: prod_reg <= prod_in;
            FE_ABS: begin
                num_mag_reg <= prod_reg[NUM_BITS-1] ? prod_neg[MAG_BITS-1:0]
                                                    : prod_reg[MAG_BITS-1:0];
                den_mag_reg <= den_reg[DIFF_BITS-1] ? unsigned'(den_neg)
                                                    : unsigned'(den_reg);
                neg_reg     <= prod_reg[NUM_BITS-1] ^ den_reg[DIFF_BITS-1];
            end
            FE_CHK: begin
                if (over) begin
                    drop_reg <= 1'b1;
                end
                rem_reg  <= num_mag_reg;
                dsh_reg  <= MAG_BITS'({den_mag_reg, {(BIN_BITS-1){1'b0}}});
                quo_reg  <= '0;
                step_reg <= STEP_BITS'(BIN_BITS - 1);
            end
            FE_DIV: begin
                if (rem_ge) begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                quo_reg  <= {quo_reg[BIN_BITS-2:0], rem_ge};
                dsh_reg  <= dsh_reg >> 1;
                step_reg <= step_reg - STEP_BITS'(1);
            end
            default: ;
        endcase
    end

endmodule

// ===== hw/rtl/vrh_queue.sv =====
// Short command queue between the classifier and the counter stage.
module vrh_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  vrh_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop_ready,
    output vrh_pkg::cmd_t pop_cmd
);
    import vrh_pkg::*;

    cmd_t                 entry_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign push_ready = (count_reg != (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + (QPTR_BITS+1)'(1);
                2'b01:   count_reg <= count_reg - (QPTR_BITS+1)'(1);
                default: ;
            endcase
        end
    end

endmodule

// ===== hw/rtl/vrh_back.sv =====
// Back part: counter memory read-modify-write and the result register.
module vrh_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             pop_valid,
    output logic                             pop_ready,
    input  vrh_pkg::cmd_t                    pop_cmd,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [vrh_pkg::BIN_BITS-1:0]     m_bin_slot,
    output logic                             m_counted,
    output logic [vrh_pkg::COUNT_BITS-1:0]   m_bin_count
);
    import vrh_pkg::*;

    be_state_t state_reg, state_next;

    cmd_t                  cmd_reg;
    logic [BINS-1:0]       valid_reg;
    logic                  out_valid_reg;
    logic [BIN_BITS-1:0]   out_slot_reg;
    logic                  out_counted_reg;
    logic [COUNT_BITS-1:0] out_count_reg;

    logic                  pop;
    logic                  ram_re;
    logic                  ram_we;
    logic [COUNT_BITS-1:0] ram_rdata;
    logic [COUNT_BITS-1:0] ram_wdata;
    logic [COUNT_BITS-1:0] cur_count;
    logic                  fill;

    vrh_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (BINS)
    ) u_counters (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (cmd_reg.slot),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (pop_cmd.slot),
        .rdata (ram_rdata)
    );

    assign pop = pop_valid && pop_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            BE_IDLE: begin
                if (pop) begin
                    state_next = BE_READ;
                end
            end
            BE_READ: state_next = BE_IDLE;
            default: state_next = BE_IDLE;
        endcase
    end

    // A bin never written since reset reads as zero
    assign cur_count = valid_reg[cmd_reg.slot] ? ram_rdata : '0;
    assign ram_wdata = (cur_count == '1) ? cur_count : cur_count + COUNT_BITS'(1);

    always_comb begin
        // Take a command only when the result register is free by the next cycle
        pop_ready = (state_reg == BE_IDLE) && (!out_valid_reg || m_ready);
        ram_re    = pop && (pop_cmd.kind != OP_NONE);
        fill      = (state_reg == BE_READ);
        ram_we    = fill && (cmd_reg.kind == OP_ADD);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= BE_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (fill) begin
                case (cmd_reg.kind)
                    OP_ADD:        valid_reg[cmd_reg.slot] <= 1'b1;
                    OP_READ_CLEAR: valid_reg[cmd_reg.slot] <= 1'b0;
                    default: ;
                endcase
            end
            if (fill) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cmd_reg <= pop_cmd;
        end
        if (fill) begin
            case (cmd_reg.kind)
                OP_ADD: begin
                    out_slot_reg    <= cmd_reg.slot;
                    out_counted_reg <= 1'b1;
                    out_count_reg   <= ram_wdata;
                end
                OP_READ, OP_READ_CLEAR: begin
                    out_slot_reg    <= cmd_reg.slot;
                    out_counted_reg <= 1'b0;
                    out_count_reg   <= cur_count;
                end
                default: begin
                    out_slot_reg    <= '0;
                    out_counted_reg <= 1'b0;
                    out_count_reg   <= '0;
                end
            endcase
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_bin_slot  = out_slot_reg;
    assign m_counted   = out_counted_reg;
    assign m_bin_count = out_count_reg;

    a_read_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BE_READ |=> state_reg == BE_IDLE)
        else $error("counter stage stayed in read");

    a_read_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BE_READ |=> out_valid_reg)
        else $error("command finished without a result");

    a_counted_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_counted_reg |-> out_count_reg != '0)
        else $error("counted result with zero count");

    a_clear_drops_bin: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BE_READ && cmd_reg.kind == OP_READ_CLEAR |=> !valid_reg[cmd_reg.slot])
        else $error("cleared bin still marked written");

    a_add_marks_bin: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == BE_READ && cmd_reg.kind == OP_ADD |=> valid_reg[cmd_reg.slot])
        else $error("counted bin not marked written");

endmodule

// ===== dv/value_range_histogram_tb.sv =====
// Self-checking testbench for value_range_histogram: directed table, then randomized phases.
module value_range_histogram_tb;
    import vrh_pkg::*;

    localparam int CLK_HALF        = 10;
    localparam int RESET_CYCLES    = 8;
    localparam int SETTLE_CYCLES   = 32;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int CYCLE_LIMIT     = 600000;
    localparam int MAX_REPORTS     = 50;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED = 2'd3;

    typedef struct packed {
        logic [BIN_BITS-1:0]   slot;
        logic                  counted;
        logic [COUNT_BITS-1:0] count;
    } bin_report_t;

    typedef struct packed {
        bit                        is_write;
        logic [CFG_INDEX_BITS-1:0] reg_index;
        logic [DATA_BITS-1:0]      reg_value;
        op_t                       op;
        logic [DATA_BITS-1:0]      sample;
        logic [BIN_BITS-1:0]       bin_index;
        bit                        typed;
        bin_report_t               want;
    } plan_row_t;

    logic                      aclk;
    logic                      aresetn;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [DATA_BITS-1:0]      cfg_wdata;
    logic                      s_valid;
    logic                      s_ready;
    logic [OP_BITS-1:0]        s_operation;
    logic signed [DATA_BITS-1:0] s_sample;
    logic [BIN_BITS-1:0]       s_bin_index;
    logic                      m_valid;
    logic                      m_ready;
    logic [BIN_BITS-1:0]       m_bin_slot;
    logic                      m_counted;
    logic [COUNT_BITS-1:0]     m_bin_count;

    // Shadow copy of the histogram and its settings
    logic [COUNT_BITS-1:0]       shadow_counts [BINS];
    logic signed [DATA_BITS-1:0] cfg_lower;
    logic signed [DATA_BITS-1:0] cfg_upper;
    logic [NBINS_BITS-1:0]       cfg_bins;

    bin_report_t bin_reports_due [$];
    plan_row_t   directed_plan [$];

    int mismatches;
    int results_checked;
    int samples_counted;
    int samples_dropped;
    int reads_done;
    int clears_done;
    int idle_ops;
    int settings_applied;
    int cycles;
    int ready_tick;

    value_range_histogram dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_sample    (s_sample),
        .s_bin_index (s_bin_index),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_bin_slot  (m_bin_slot),
        .m_counted   (m_counted),
        .m_bin_count (m_bin_count)
    );

    initial begin
        aclk = 1'b0;
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic bin_report_t predict_bin_report(op_t op, logic signed [DATA_BITS-1:0] sample,
                                                       logic [BIN_BITS-1:0] idx);
        bin_report_t r;
        longint n;
        longint lo;
        longint den;
        longint num;
        longint q;
        logic [BIN_BITS-1:0] qi;
        r = '0;
        case (op)
            OP_ADD: begin
                n   = longint'(cfg_bins);
                lo  = longint'(cfg_lower);
                den = longint'(cfg_upper) - lo;
                if (n > BINS) n = BINS;
                if (n > 0 && den != 0) begin
                    // signed division truncates toward zero
                    num = (n - 1) * (longint'(sample) - lo);
                    q   = num / den;
                    if (q >= 0 && q < n) begin
                        qi = q[BIN_BITS-1:0];
                        if (shadow_counts[qi] != '1) shadow_counts[qi] = shadow_counts[qi] + 1'b1;
                        r.slot    = qi;
                        r.counted = 1'b1;
                        r.count   = shadow_counts[qi];
                    end
                end
            end
            OP_READ, OP_READ_CLEAR: begin
                r.slot  = idx;
                r.count = shadow_counts[idx];
                if (op == OP_READ_CLEAR) shadow_counts[idx] = '0;
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic plan_row_t reg_row(logic [CFG_INDEX_BITS-1:0] idx, logic [DATA_BITS-1:0] val);
        plan_row_t r;
        r = '0;
        r.is_write  = 1'b1;
        r.reg_index = idx;
        r.reg_value = val;
        return r;
    endfunction

    function automatic plan_row_t item_row(op_t op, logic [DATA_BITS-1:0] sample,
                                           logic [BIN_BITS-1:0] idx, bit typed,
                                           logic [BIN_BITS-1:0] slot, logic counted,
                                           logic [COUNT_BITS-1:0] count);
        plan_row_t r;
        r = '0;
        r.op           = op;
        r.sample       = sample;
        r.bin_index    = idx;
        r.typed        = typed;
        r.want.slot    = slot;
        r.want.counted = counted;
        r.want.count   = count;
        return r;
    endfunction

    function automatic plan_row_t random_row();
        plan_row_t r;
        int pick;
        int n_eff;
        longint lo_v;
        longint hi_v;
        longint span;
        r = '0;
        r.sample    = $urandom;
        r.bin_index = BIN_BITS'($urandom_range(0, BINS - 1));
        pick  = $urandom_range(0, 99);
        lo_v  = longint'(cfg_lower);
        hi_v  = longint'(cfg_upper);
        if (lo_v > hi_v) begin
            span = lo_v;
            lo_v = hi_v;
            hi_v = span;
        end
        span  = hi_v - lo_v;
        n_eff = (cfg_bins > BINS) ? BINS : int'(cfg_bins);
        if (pick < 70) begin
            r.op = OP_ADD;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6:
                    r.sample = 32'(lo_v + longint'({$urandom, $urandom} % (span + 1)));
                7: r.sample = 32'(($urandom_range(0, 1) ? lo_v : hi_v) + $urandom_range(0, 8) - 4);
                8: r.sample = $urandom;
                default: r.sample = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            endcase
        end else begin
            r.op = (pick < 82) ? OP_READ : (pick < 94) ? OP_READ_CLEAR : OP_NONE;
            if (n_eff > 0 && $urandom_range(0, 3) != 0)
                r.bin_index = BIN_BITS'($urandom_range(0, n_eff - 1));
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch %0d at cycle %0d: %s got 0x%0h expected 0x%0h",
                     mismatches, cycles, what, got, want);
    endtask

    task automatic send_item(plan_row_t row);
        bin_report_t predicted;
        @(negedge aclk);
        s_valid     <= 1'b1;
        s_operation <= row.op;
        s_sample    <= row.sample;
        s_bin_index <= row.bin_index;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        predicted = predict_bin_report(row.op, row.sample, row.bin_index);
        bin_reports_due.push_back(row.typed ? row.want : predicted);
        case (row.op)
            OP_ADD:        if (predicted.counted) samples_counted++; else samples_dropped++;
            OP_READ:       reads_done++;
            OP_READ_CLEAR: clears_done++;
            default:       idle_ops++;
        endcase
    endtask

    task automatic idle_gap(int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // Hold off until every pending result has drained and the pipeline has settled
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (bin_reports_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [DATA_BITS-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_LOWER_BOUND: cfg_lower = val;
            CFG_UPPER_BOUND: cfg_upper = val;
            CFG_BINS_IN_USE: cfg_bins  = val[NBINS_BITS-1:0];
            default: ;
        endcase
        settings_applied++;
    endtask

    // Receiver: cycle through full rate, random stalls, fixed rhythm and long stalls
    initial begin
        m_ready    = 1'b0;
        ready_tick = 0;
        forever begin
            @(negedge aclk);
            ready_tick++;
            case ((ready_tick / 256) % 4)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 3) != 0);
                2:       m_ready <= ((ready_tick % 7) < 3);
                default: m_ready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    always @(posedge aclk) begin : result_check
        bin_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (bin_reports_due.size() == 0) begin
                report_mismatch("result with nothing pending, bin_slot", m_bin_slot, 0);
            end else begin
                want = bin_reports_due.pop_front();
                results_checked++;
                if (m_bin_slot !== want.slot)     report_mismatch("bin_slot", m_bin_slot, want.slot);
                if (m_counted !== want.counted)   report_mismatch("counted", m_counted, want.counted);
                if (m_bin_count !== want.count)   report_mismatch("bin_count", m_bin_count, want.count);
            end
        end
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d results pending", cycles, bin_reports_due.size());
        $display("status: fail");
        $finish;
    end

    initial begin
        plan_row_t row;
        int ph;
        int k;
        int burst_left;
        logic [DATA_BITS-1:0] lo;
        logic [DATA_BITS-1:0] up;
        logic [NBINS_BITS-1:0] nb;

        aresetn     = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_LOWER_BOUND;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_operation = OP_ADD;
        s_sample    = '0;
        s_bin_index = '0;
        mismatches       = 0;
        results_checked  = 0;
        samples_counted  = 0;
        samples_dropped  = 0;
        reads_done       = 0;
        clears_done      = 0;
        idle_ops         = 0;
        settings_applied = 0;
        foreach (shadow_counts[i]) shadow_counts[i] = '0;
        cfg_lower = LOWER_RESET;
        cfg_upper = UPPER_RESET;
        cfg_bins  = BINS_RESET;

        // Reset settings: range 0.0 to 1.0 over 256 bins
        directed_plan.push_back(item_row(OP_ADD, 32'd0, 8'd0, 1, 8'd0, 1'b1, 32'd1));
        directed_plan.push_back(item_row(OP_ADD, 32'd65536, 8'd0, 1, 8'd255, 1'b1, 32'd1));
        // just below lower still truncates into bin 0
        directed_plan.push_back(item_row(OP_ADD, 32'hFFFF_FFFF, 8'd0, 1, 8'd0, 1'b1, 32'd2));
        directed_plan.push_back(item_row(OP_ADD, 32'hFFFF_0000, 8'd0, 1, 8'd0, 1'b0, 32'd0));
        directed_plan.push_back(item_row(OP_ADD, 32'h7FFF_FFFF, 8'd0, 1, 8'd0, 1'b0, 32'd0));
        directed_plan.push_back(item_row(OP_ADD, 32'h8000_0000, 8'd0, 1, 8'd0, 1'b0, 32'd0));
        directed_plan.push_back(item_row(OP_READ, 32'd0, 8'd0, 1, 8'd0, 1'b0, 32'd2));
        directed_plan.push_back(item_row(OP_READ_CLEAR, 32'd0, 8'd0, 1, 8'd0, 1'b0, 32'd2));
        directed_plan.push_back(item_row(OP_READ, 32'd0, 8'd0, 1, 8'd0, 1'b0, 32'd0));
        directed_plan.push_back(item_row(OP_NONE, 32'hFFFF_FFFF, 8'hFF, 1, 8'd0, 1'b0, 32'd0));
        directed_plan.push_back(item_row(OP_READ, 32'd0, 8'd255, 1, 8'd255, 1'b0, 32'd1));
        directed_plan.push_back(item_row(OP_READ, 32'd0, 8'd17, 1, 8'd17, 1'b0, 32'd0));
        // unmapped register index must leave all settings alone
        directed_plan.push_back(reg_row(CFG_UNMAPPED, 32'd0));
        directed_plan.push_back(item_row(OP_ADD, 32'd65536, 8'd0, 1, 8'd255, 1'b1, 32'd2));
        directed_plan.push_back(reg_row(CFG_BINS_IN_USE, 32'd1));
        directed_plan.push_back(item_row(OP_ADD, 32'h7FFF_FFFF, 8'd0, 1, 8'd0, 1'b1, 32'd1));
        directed_plan.push_back(reg_row(CFG_BINS_IN_USE, 32'd0));
        directed_plan.push_back(item_row(OP_ADD, 32'd0, 8'd0, 1, 8'd0, 1'b0, 32'd0));
        // bins above the array size saturate
        directed_plan.push_back(reg_row(CFG_BINS_IN_USE, 32'h1FF));
        directed_plan.push_back(item_row(OP_ADD, 32'd65536, 8'd0, 1, 8'd255, 1'b1, 32'd3));
        directed_plan.push_back(reg_row(CFG_UPPER_BOUND, 32'd0));
        directed_plan.push_back(item_row(OP_ADD, 32'd0, 8'd0, 1, 8'd0, 1'b0, 32'd0));
        // widest reversed range, then widest forward range
        directed_plan.push_back(reg_row(CFG_LOWER_BOUND, 32'h7FFF_FFFF));
        directed_plan.push_back(reg_row(CFG_UPPER_BOUND, 32'h8000_0000));
        directed_plan.push_back(item_row(OP_ADD, 32'h8000_0000, 8'd0, 0, '0, 1'b0, '0));
        directed_plan.push_back(item_row(OP_ADD, 32'd0, 8'd0, 0, '0, 1'b0, '0));
        directed_plan.push_back(item_row(OP_ADD, 32'h7FFF_FFFF, 8'd0, 0, '0, 1'b0, '0));
        directed_plan.push_back(reg_row(CFG_LOWER_BOUND, 32'h8000_0000));
        directed_plan.push_back(reg_row(CFG_UPPER_BOUND, 32'h7FFF_FFFF));
        directed_plan.push_back(item_row(OP_ADD, 32'h7FFF_FFFF, 8'd0, 0, '0, 1'b0, '0));
        directed_plan.push_back(item_row(OP_ADD, 32'h8000_0000, 8'd0, 0, '0, 1'b0, '0));
        directed_plan.push_back(item_row(OP_READ_CLEAR, 32'h5A5A_A5A5, 8'd255, 0, '0, 1'b0, '0));

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_plan[i]) begin
            row = directed_plan[i];
            if (row.is_write) begin
                drain_results();
                write_reg(row.reg_index, row.reg_value);
            end else begin
                send_item(row);
            end
        end

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin lo = 32'd0;         up = 32'd65536;     nb = 9'd256; end
                1: begin lo = 32'hFFFF_0000; up = 32'h0003_0000; nb = 9'd16;  end
                2: begin lo = $urandom;      up = $urandom;      nb = 9'd1;   end
                3: begin lo = 32'h8000_0000; up = 32'h7FFF_FFFF; nb = 9'h1FF; end
                default: begin
                    lo = $urandom;
                    case ($urandom_range(0, 3))
                        0: up = $urandom;
                        1: up = lo + $urandom_range(1, 1 << 20);
                        2: up = lo - $urandom_range(1, 1 << 20);
                        default: up = lo + $urandom_range(0, 3);
                    endcase
                    nb = NBINS_BITS'($urandom_range(0, 511));
                end
            endcase
            drain_results();
            write_reg(CFG_LOWER_BOUND, lo);
            write_reg(CFG_UPPER_BOUND, up);
            write_reg(CFG_BINS_IN_USE, {{(DATA_BITS-NBINS_BITS){1'b0}}, nb});
            burst_left = 0;
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    // every third phase streams back to back
                    if (ph % 3 != 0) idle_gap($urandom_range(0, 12));
                end
                burst_left--;
                if (ph == 2 && k == ITEMS_PER_PHASE / 2) drain_results();
                send_item(random_row());
            end
        end

        drain_results();
        $display("covered %0d counted and %0d dropped samples, %0d reads, %0d clearing reads, %0d no-ops",
                 samples_counted, samples_dropped, reads_done, clears_done, idle_ops);
        $display("%0d register writes, %0d results checked, %0d mismatches",
                 settings_applied, results_checked, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/vrh_pkg.sv
hw/rtl/vrh_ram.sv
hw/rtl/vrh_front.sv
hw/rtl/vrh_queue.sv
hw/rtl/vrh_back.sv
hw/rtl/value_range_histogram.sv
dv/value_range_histogram_tb.sv
